// ===== rtl/ap3d_pkg.sv =====
// Shared types and constants for the 3D average pooling block.
package ap3d_pkg;

  localparam int unsigned MAX_IN_WIDTH_DEF = 1024;
  localparam int unsigned MAX_POOL_DEF     = 16;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned CH_W       = 16;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned IN_W_W     = 11;
  localparam int unsigned POOL_REG_W = 5;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_CHANNELS   = 3'd0,
    REG_IN_HEIGHT     = 3'd1,
    REG_IN_WIDTH      = 3'd2,
    REG_POOL_CHANNELS = 3'd3,
    REG_POOL_HEIGHT   = 3'd4,
    REG_POOL_WIDTH    = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_DIV,
    ST_FIX_COL,
    ST_FIX_ROW,
    ST_FIX_CHAN
  } ap3d_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ===== rtl/ap3d_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ap3d_div import ap3d_pkg::*; #(
  parameter int unsigned N = SUM_W,
  parameter int unsigned D = 15
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output div_status_t  status_o,
  output logic [N-1:0] quot_o,
  output logic [D-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(N + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [N-1:0]     quot_q;
  logic [D-1:0]     rem_q, div_q;
  logic [D:0]       trial, diff;
  logic             ge;

  assign trial = {rem_q, quot_q[N-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(N);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= {quot_q[N-2:0], ge};
      // remainder stays below the divisor, so it fits D bits
      rem_q  <= ge ? diff[D-1:0] : trial[D-1:0];
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quot_q;
  assign rem_o         = rem_q;

endmodule

// ===== rtl/avg_pool_3d_u8.sv =====
// Top level of the 3D average pooling block: config, position tracking, sum memory.
//
//   channel   direction  handshake              payload
//   in        request    in_valid_i/in_stall_o  pixel_i
//   out       result     out_valid_o/out_stall_i average_o, last_of_tensor_o
//   cfg       write      cfg_we_i               cfg_idx_i, cfg_data_i
//
// An element that does not close a window lets the next request in while its sum
// is written back, unless a config write is pending; back-to-back requests
// hit the same sum entry through a forwarding register. An element that closes a
// window holds off requests until the bit-serial divider has formed the average.
// After a config write, the divider re-derives the window offsets from the kept
// positions in three passes (column, row, channel); a lone write holds off the
// next request until the passes end, and a write during a pass forces a new round.
// The sum memory is not cleared at reset; the first element of a window overwrites
// its entry. A full output register holds back only a window-closing element.
module avg_pool_3d_u8 import ap3d_pkg::*; #(
  parameter int unsigned MAX_IN_WIDTH = MAX_IN_WIDTH_DEF,
  parameter int unsigned MAX_POOL     = MAX_POOL_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [PIX_W-1:0]     pixel_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [PIX_W-1:0]     average_o,
  output logic                 last_of_tensor_o
);

  localparam int unsigned CW    = (MAX_IN_WIDTH > 1) ? $clog2(MAX_IN_WIDTH) : 1;
  localparam int unsigned PW    = $clog2(MAX_POOL + 1);
  localparam int unsigned RCW   = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int unsigned VOL_W = 3 * PW;

  // config registers
  logic [CH_W-1:0]       in_ch_q;
  logic [ROW_W-1:0]      in_h_q;
  logic [IN_W_W-1:0]     in_w_q;
  logic [POOL_REG_W-1:0] pool_c_q, pool_h_q, pool_w_q;

  // positions and window offsets
  logic [CH_W-1:0]  chan_q;
  logic [ROW_W-1:0] row_q;
  logic [CW-1:0]    col_q, oc_q;
  logic [RCW-1:0]   rc_q, rh_q, rw_q;
  logic             dirty_q;

  // read-modify-write stage
  logic [PIX_W-1:0] s_pix_q;
  logic             s_first_q, s_last_q, s_end_q;
  logic [CW-1:0]    s_oc_q;
  logic             fwd_q;
  logic [SUM_W-1:0] fwd_data_q, rd_data_q;
  logic [SUM_W-1:0] sums_mem [MAX_IN_WIDTH];

  logic             out_valid_q, out_last_q;
  logic [PIX_W-1:0] avg_q;

  ap3d_state_e state_q, state_d;

  logic [CH_W-1:0]   nc;
  logic [ROW_W-1:0]  nh;
  logic [IN_W_W-1:0] nw;
  logic [PW-1:0]     pc, ph, pw;
  logic [VOL_W-1:0]  vol;

  logic [CW-1:0]    col_inc;
  logic [ROW_W-1:0] row_inc;
  logic [CH_W-1:0]  chan_inc;
  logic             col_wrap, row_wrap, chan_wrap;
  logic             rw_last, rh_last, rc_last;
  logic             first, last, tensor_end;

  logic [SUM_W-1:0] base, sum;
  logic [SUM_W:0]   add;
  logic [PIX_W-1:0] avg;

  logic             accept, div_start, load_out, mem_we, in_stall, out_free;
  logic             cap_col, cap_row, cap_chan;
  logic [SUM_W-1:0] div_a, div_quot;
  logic [VOL_W-1:0] div_b, div_rem;
  div_status_t      div_st;

  function automatic logic [PW-1:0] pool_ext(input logic [POOL_REG_W-1:0] v);
    if (v == '0) begin
      return PW'(1);
    end else if (32'(v) > MAX_POOL) begin
      return PW'(MAX_POOL);
    end else begin
      return PW'(v);
    end
  endfunction

  assign nc = (in_ch_q == '0) ? CH_W'(1) : in_ch_q;
  assign nh = (in_h_q == '0) ? ROW_W'(1) : in_h_q;
  always_comb begin
    if (in_w_q == '0) begin
      nw = IN_W_W'(1);
    end else if (32'(in_w_q) > MAX_IN_WIDTH) begin
      nw = IN_W_W'(MAX_IN_WIDTH);
    end else begin
      nw = in_w_q;
    end
  end
  assign pc  = pool_ext(pool_c_q);
  assign ph  = pool_ext(pool_h_q);
  assign pw  = pool_ext(pool_w_q);
  assign vol = VOL_W'(pc) * VOL_W'(ph) * VOL_W'(pw);

  assign col_inc   = col_q + CW'(1);
  assign row_inc   = row_q + ROW_W'(1);
  assign chan_inc  = chan_q + CH_W'(1);
  assign col_wrap  = (col_inc == '0) || (32'(col_inc) >= 32'(nw));
  assign row_wrap  = (row_inc == '0) || (row_inc >= nh);
  assign chan_wrap = chan_inc >= nc;

  assign rw_last = PW'(rw_q) == pw - PW'(1);
  assign rh_last = PW'(rh_q) == ph - PW'(1);
  assign rc_last = PW'(rc_q) == pc - PW'(1);
  assign first   = (rc_q == '0) && (rh_q == '0) && (rw_q == '0);
  assign last    = rc_last && rh_last && rw_last;
  assign tensor_end = (chan_q == nc - CH_W'(1)) && (row_q == nh - ROW_W'(1)) &&
                      (32'(col_q) == 32'(nw) - 32'd1);

  assign base = fwd_q ? fwd_data_q : rd_data_q;
  assign add  = {1'b0, base} + (SUM_W + 1)'(s_pix_q);
  assign sum  = s_first_q ? SUM_W'(s_pix_q) : (add[SUM_W] ? '1 : add[SUM_W-1:0]);
  assign avg  = (|div_quot[SUM_W-1:PIX_W]) ? '1 : div_quot[PIX_W-1:0];

  assign out_free = !out_valid_q || !out_stall_i;

  ap3d_div #(
    .N (SUM_W),
    .D (VOL_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .status_o   (div_st),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    accept    = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    mem_we    = 1'b0;
    in_stall  = 1'b1;
    cap_col   = 1'b0;
    cap_row   = 1'b0;
    cap_chan  = 1'b0;
    div_a     = sum;
    div_b     = vol;
    case (state_q)
      ST_IDLE: begin
        div_a = SUM_W'(col_q);
        div_b = VOL_W'(pw);
        if (dirty_q) begin
          div_start = 1'b1;
          state_d   = ST_FIX_COL;
        end else begin
          in_stall = 1'b0;
          if (in_valid_i) begin
            accept  = 1'b1;
            state_d = ST_RMW;
          end
        end
      end
      ST_RMW: begin
        mem_we = 1'b1;
        if (s_last_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else if (dirty_q) begin
          state_d = ST_IDLE;
        end else begin
          in_stall = 1'b0;
          if (in_valid_i) begin
            accept = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (!div_st.busy && out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_FIX_COL: begin
        div_a = SUM_W'(row_q);
        div_b = VOL_W'(ph);
        if (div_st.done) begin
          cap_col   = 1'b1;
          div_start = 1'b1;
          state_d   = ST_FIX_ROW;
        end
      end
      ST_FIX_ROW: begin
        div_a = SUM_W'(chan_q);
        div_b = VOL_W'(pc);
        if (div_st.done) begin
          cap_row   = 1'b1;
          div_start = 1'b1;
          state_d   = ST_FIX_CHAN;
        end
      end
      ST_FIX_CHAN: begin
        if (div_st.done) begin
          cap_chan = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = in_stall;

  // config writes; offsets are re-derived afterwards
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch_q  <= CH_W'(1);
      in_h_q   <= ROW_W'(1);
      in_w_q   <= IN_W_W'(1);
      pool_c_q <= POOL_REG_W'(1);
      pool_h_q <= POOL_REG_W'(1);
      pool_w_q <= POOL_REG_W'(1);
      dirty_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dirty_q <= 1'b1;
        case (cfg_idx_i)
          REG_IN_CHANNELS:   in_ch_q  <= cfg_data_i[CH_W-1:0];
          REG_IN_HEIGHT:     in_h_q   <= cfg_data_i[ROW_W-1:0];
          REG_IN_WIDTH:      in_w_q   <= cfg_data_i[IN_W_W-1:0];
          REG_POOL_CHANNELS: pool_c_q <= cfg_data_i[POOL_REG_W-1:0];
          REG_POOL_HEIGHT:   pool_h_q <= cfg_data_i[POOL_REG_W-1:0];
          REG_POOL_WIDTH:    pool_w_q <= cfg_data_i[POOL_REG_W-1:0];
          default: ;
        endcase
      end else if (state_q == ST_IDLE && dirty_q) begin
        dirty_q <= 1'b0;
      end
    end
  end

  // raster position and window offsets
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
      oc_q   <= '0;
      rc_q   <= '0;
      rh_q   <= '0;
      rw_q   <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_q <= '0;
        oc_q  <= '0;
        rw_q  <= '0;
        if (row_wrap) begin
          row_q  <= '0;
          rh_q   <= '0;
          chan_q <= chan_wrap ? '0 : chan_inc;
          rc_q   <= (chan_wrap || rc_last) ? '0 : rc_q + RCW'(1);
        end else begin
          row_q <= row_inc;
          rh_q  <= rh_last ? '0 : rh_q + RCW'(1);
        end
      end else begin
        col_q <= col_inc;
        rw_q  <= rw_last ? '0 : rw_q + RCW'(1);
        oc_q  <= rw_last ? oc_q + CW'(1) : oc_q;
      end
    end else if (cap_col) begin
      oc_q <= div_quot[CW-1:0];
      rw_q <= div_rem[RCW-1:0];
    end else if (cap_row) begin
      rh_q <= div_rem[RCW-1:0];
    end else if (cap_chan) begin
      rc_q <= div_rem[RCW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_pix_q    <= pixel_i;
      s_first_q  <= first;
      s_last_q   <= last;
      s_end_q    <= tensor_end;
      s_oc_q     <= oc_q;
      // entry being written this cycle is read back stale, so forward it
      fwd_q      <= (state_q == ST_RMW) && (oc_q == s_oc_q);
      fwd_data_q <= sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sums_mem[s_oc_q] <= sum;
    end
    if (accept) begin
      rd_data_q <= sums_mem[oc_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      avg_q      <= avg;
      out_last_q <= s_end_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign average_o        = avg_q;
  assign last_of_tensor_o = out_last_q;

endmodule
